FILE: sv/framebuffer_shape_drawer_top_defines.svh
// Assertion helpers for the shape drawer.
`ifndef FRAMEBUFFER_SHAPE_DRAWER_TOP_DEFINES_SVH
`define FRAMEBUFFER_SHAPE_DRAWER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define FSD_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fsd: check failed");
// next-cycle implication
`define FSD_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fsd: check failed");
`else
`define FSD_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define FSD_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif

`endif

FILE: sv/fsd_pkg.sv
package fsd_pkg;

    // frame geometry
    localparam int FRAME_SIDE  = 256;
    localparam int ANGLE_POINTS = 629;
    localparam int COORD_W     = $clog2(FRAME_SIDE);
    localparam int ADDR_W      = $clog2(FRAME_SIDE * FRAME_SIDE);
    localparam int DEPTH       = FRAME_SIDE * FRAME_SIDE;
    localparam int PIX_W       = 8;
    localparam int FIELD_W     = 10;
    localparam int IN_DATA_W   = 4 * FIELD_W;
    localparam int MODE_W      = 2;
    localparam int PW          = 12;    // signed working coordinate
    localparam int K_W         = $clog2(ANGLE_POINTS);

    // rotation recurrence, Q30
    localparam int Q30_W   = 32;
    localparam int MAG_W   = 31;
    localparam int CST_W   = 30;
    localparam int PROD_W  = MAG_W + CST_W;
    localparam int Q30_SH  = 30;
    localparam int Q15_W   = 17;
    localparam int Q15_SH  = 15;
    localparam int Q15_ONE = 32768;
    localparam int DR_W    = FIELD_W + Q15_W;
    localparam int TRUNC_SH = 16;

    localparam logic signed [Q30_W-1:0] Q30_ONE   = Q30_W'(1073741824);
    localparam logic [CST_W-1:0]        STEP_COS  = CST_W'(1073688137);
    localparam logic [CST_W-1:0]        STEP_SIN  = CST_W'(10737239);
    localparam logic [PROD_W-1:0]       ROUND_Q30 = PROD_W'(1) << (Q30_SH - 1);
    localparam logic [Q30_W-1:0]        ROUND_Q15 = Q30_W'(1) << (Q15_SH - 1);

    localparam logic [PIX_W-1:0] PIX_WHITE = PIX_W'(255);
    localparam logic [PIX_W-1:0] PIX_BLACK = PIX_W'(0);

    localparam logic signed [PW-1:0]  FS_LAST    = PW'(FRAME_SIDE - 1);
    localparam logic signed [PW-1:0]  FS_SIZE    = PW'(FRAME_SIDE);
    localparam logic [ADDR_W-1:0]     ROW_STRIDE = ADDR_W'(FRAME_SIDE);
    localparam logic [ADDR_W-1:0]     ADDR_LAST  = ADDR_W'(DEPTH - 1);
    localparam logic [K_W-1:0]        K_LAST     = K_W'(ANGLE_POINTS - 1);

    typedef enum logic [MODE_W-1:0] {
        MODE_RECT = 2'd0,
        MODE_OVAL = 2'd1,
        MODE_READ = 2'd2,
        MODE_NOP  = 2'd3
    } t_mode;

    typedef struct packed {
        t_mode                     mode;
        logic signed [FIELD_W-1:0] row;
        logic signed [FIELD_W-1:0] col;
        logic signed [FIELD_W-1:0] height;
        logic signed [FIELD_W-1:0] width;
    } t_item;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RECT_SETUP,
        ST_RECT_CHECK,
        ST_RECT_RUN,
        ST_OVAL,
        ST_READ,
        ST_FINISH
    } t_state;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_RECT_SETUP,
        OP_RECT_STEP,
        OP_OVAL,
        OP_READ,
        OP_PUSH
    } t_op;

    // per-point schedule of the ellipse
    typedef enum logic [2:0] {
        OV_Q15,
        OV_SCALE,
        OV_OFFSET,
        OV_PLOT,
        OV_DRAIN0,
        OV_DRAIN1,
        OV_DRAIN2,
        OV_COMMIT
    } t_ov_step;

    typedef struct packed {
        t_op      op;
        t_ov_step step;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic rect_empty;
        logic rect_last_col;
        logic rect_last_row;
        logic out_free;
    } t_status;

    typedef struct packed {
        logic vld;
        logic sub;
        logic dst_s;
        logic first;
    } t_mac_ctl;

    function automatic logic signed [Q15_W-1:0] q30_to_q15(input logic signed [Q30_W-1:0] v);
        logic [Q30_W-1:0] mag;
        logic [Q30_W-1:0] q;
        mag = v[Q30_W-1] ? Q30_W'(-v) : Q30_W'(v);
        q   = (mag + ROUND_Q15) >> Q15_SH;
        if (q > Q30_W'(Q15_ONE)) begin
            q = Q30_W'(Q15_ONE);
        end
        return v[Q30_W-1] ? -$signed(Q15_W'(q)) : $signed(Q15_W'(q));
    endfunction

    // divide by 2^16, rounding toward zero
    function automatic logic signed [PW-1:0] trunc_q16(input logic signed [DR_W-1:0] a);
        logic [DR_W-1:0] mag;
        logic [PW-1:0]   q;
        mag = a[DR_W-1] ? DR_W'(-a) : DR_W'(a);
        q   = PW'(mag >> TRUNC_SH);
        return a[DR_W-1] ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic in_frame(input logic signed [PW-1:0] r,
                                      input logic signed [PW-1:0] c);
        return !r[PW-1] && (r < FS_SIZE) && !c[PW-1] && (c < FS_SIZE);
    endfunction

    function automatic logic [ADDR_W-1:0] pix_addr(input logic signed [PW-1:0] r,
                                                   input logic signed [PW-1:0] c);
        return ADDR_W'(r[COORD_W-1:0]) * ROW_STRIDE + ADDR_W'(c[COORD_W-1:0]);
    endfunction

endpackage

FILE: sv/fsd_ram.sv
module fsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/fsd_ctrl.sv
`include "framebuffer_shape_drawer_top_defines.svh"

module fsd_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  fsd_pkg::t_mode   i_mode,
    input  fsd_pkg::t_status i_status,
    output fsd_pkg::t_cmd    o_cmd
);

    import fsd_pkg::*;

    t_state          r_state, n_state;
    t_ov_step        r_step, n_step;
    logic [K_W-1:0]  r_k, n_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_step  <= OV_Q15;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_k     <= n_k;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        n_k        = r_k;
        o_in_ready = 1'b0;
        o_cmd.op   = OP_NONE;
        o_cmd.step = r_step;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.op = OP_CLEAR;
                if (i_status.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    case (i_mode)
                        MODE_RECT: n_state = ST_RECT_SETUP;
                        MODE_OVAL: begin
                            n_state = ST_OVAL;
                            n_step  = OV_Q15;
                            n_k     = '0;
                        end
                        MODE_READ: n_state = ST_READ;
                        default:   n_state = ST_FINISH;
                    endcase
                end
            end
            ST_RECT_SETUP: begin
                o_cmd.op = OP_RECT_SETUP;
                n_state  = ST_RECT_CHECK;
            end
            ST_RECT_CHECK: begin
                n_state = i_status.rect_empty ? ST_FINISH : ST_RECT_RUN;
            end
            ST_RECT_RUN: begin
                o_cmd.op = OP_RECT_STEP;
                if (i_status.rect_last_col && i_status.rect_last_row) begin
                    n_state = ST_FINISH;
                end
            end
            ST_OVAL: begin
                o_cmd.op = OP_OVAL;
                n_step   = t_ov_step'(r_step + 1'b1);
                if (r_step == OV_COMMIT) begin
                    if (r_k == K_LAST) begin
                        n_state = ST_FINISH;
                    end else begin
                        n_k = r_k + 1'b1;
                    end
                end
            end
            ST_READ: begin
                o_cmd.op = OP_READ;
                n_state  = ST_FINISH;
            end
            ST_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.op = OP_PUSH;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    `FSD_ASSERT_NXT(a_clear_done, i_clk, i_rst_n, (r_state == ST_CLEAR) && i_status.clear_last, r_state == ST_IDLE)
    `FSD_ASSERT_NXT(a_rect_end, i_clk, i_rst_n, (r_state == ST_RECT_RUN) && i_status.rect_last_col && i_status.rect_last_row, r_state == ST_FINISH)
    `FSD_ASSERT_NXT(a_oval_end, i_clk, i_rst_n, (r_state == ST_OVAL) && (r_step == OV_COMMIT) && (r_k == K_LAST), r_state == ST_FINISH)
    `FSD_ASSERT_NXT(a_oval_hold, i_clk, i_rst_n, (r_state == ST_OVAL) && (r_step != OV_COMMIT), r_state == ST_OVAL)

endmodule

FILE: sv/fsd_datapath.sv
module fsd_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  fsd_pkg::t_cmd                i_cmd,
    input  fsd_pkg::t_item               i_item,
    output fsd_pkg::t_status             o_status,
    output logic                         o_ram_we,
    output logic [fsd_pkg::ADDR_W-1:0]   o_ram_waddr,
    output logic [fsd_pkg::PIX_W-1:0]    o_ram_wdata,
    output logic                         o_ram_re,
    output logic [fsd_pkg::ADDR_W-1:0]   o_ram_raddr,
    input  logic [fsd_pkg::PIX_W-1:0]    i_ram_rdata,
    output logic                         o_res_valid,
    input  logic                         i_res_ready,
    output logic [fsd_pkg::PIX_W-1:0]    o_res_pixel,
    output logic                         o_res_read
);

    import fsd_pkg::*;

    // latched request
    logic signed [FIELD_W-1:0] r_row, r_col, r_h, r_w;
    logic                      r_is_read;
    logic signed [PW-1:0]      row_x, col_x, h_x, w_x, rect_bot, rect_rgt;

    // rectangle scan
    logic signed [PW-1:0] r_bot, r_rgt, r_r1, r_c0, r_c1, r_cur_r, r_cur_c;
    logic                 is_border;

    // ellipse
    logic signed [Q30_W-1:0] r_cq, r_sq, r_acc_c, r_acc_s;
    logic signed [Q15_W-1:0] r_s15, r_c15;
    logic signed [DR_W-1:0]  r_dr, r_dc;
    logic signed [PW-1:0]    r_pr, r_pc;

    // recurrence multiply pipeline
    logic                    iss_vld, iss_sub, iss_dst_s, iss_first, iss_sin;
    logic signed [Q30_W-1:0] iss_a, iss_neg_a;
    logic [MAG_W-1:0]        iss_mag;
    logic [CST_W-1:0]        iss_cst;
    t_mac_ctl                r_ma, r_mb, r_mc;
    logic [MAG_W-1:0]        r_ma_mag;
    logic [CST_W-1:0]        r_ma_cst;
    logic [PROD_W-1:0]       r_prod, prod_rnd;
    logic signed [Q30_W-1:0] r_p, acc_base, acc_new;

    // clearing pass and result register
    logic [ADDR_W-1:0] r_clr_addr;
    logic              r_res_valid;
    logic [PIX_W-1:0]  r_res_pixel;
    logic              r_res_read;

    assign row_x    = PW'(r_row);
    assign col_x    = PW'(r_col);
    assign h_x      = PW'(r_h);
    assign w_x      = PW'(r_w);
    assign rect_bot = row_x + h_x;
    assign rect_rgt = col_x + w_x;
    assign is_border = (r_cur_r == row_x) || (r_cur_r == r_bot) ||
                       (r_cur_c == col_x) || (r_cur_c == r_rgt);

    // multiply issue: two products per new cos, two per new sin
    always_comb begin
        iss_vld   = (i_cmd.op == OP_OVAL);
        iss_a     = r_cq;
        iss_sin   = 1'b0;
        iss_sub   = 1'b0;
        iss_dst_s = 1'b0;
        iss_first = 1'b0;
        case (i_cmd.step)
            OV_Q15: begin
                iss_first = 1'b1;
            end
            OV_SCALE: begin
                iss_a   = r_sq;
                iss_sin = 1'b1;
                iss_sub = 1'b1;
            end
            OV_OFFSET: begin
                iss_a     = r_sq;
                iss_dst_s = 1'b1;
                iss_first = 1'b1;
            end
            OV_PLOT: begin
                iss_sin   = 1'b1;
                iss_dst_s = 1'b1;
            end
            default: iss_vld = 1'b0;
        endcase
    end

    assign iss_neg_a = -iss_a;
    assign iss_mag   = iss_a[Q30_W-1] ? iss_neg_a[MAG_W-1:0] : iss_a[MAG_W-1:0];
    assign iss_cst   = iss_sin ? STEP_SIN : STEP_COS;
    assign prod_rnd  = r_prod + ROUND_Q30;
    assign acc_base  = r_mc.first ? '0 : (r_mc.dst_s ? r_acc_s : r_acc_c);
    assign acc_new   = r_mc.sub ? acc_base - r_p : acc_base + r_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ma        <= '0;
            r_mb        <= '0;
            r_mc        <= '0;
            r_clr_addr  <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_ma.vld   <= iss_vld;
            r_ma.sub   <= iss_sub ^ iss_a[Q30_W-1];
            r_ma.dst_s <= iss_dst_s;
            r_ma.first <= iss_first;
            r_mb       <= r_ma;
            r_mc       <= r_mb;
            if (i_cmd.op == OP_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.op == OP_PUSH) begin
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ma_mag <= iss_mag;
        r_ma_cst <= iss_cst;
        r_prod   <= PROD_W'(r_ma_mag) * PROD_W'(r_ma_cst);
        r_p      <= Q30_W'(prod_rnd >> Q30_SH);
        if (r_mc.vld) begin
            if (r_mc.dst_s) begin
                r_acc_s <= acc_new;
            end else begin
                r_acc_c <= acc_new;
            end
        end

        case (i_cmd.op)
            OP_LOAD: begin
                r_row     <= i_item.row;
                r_col     <= i_item.col;
                r_h       <= i_item.height;
                r_w       <= i_item.width;
                r_is_read <= (i_item.mode == MODE_READ) &&
                             in_frame(PW'(i_item.row), PW'(i_item.col));
                r_cq      <= Q30_ONE;
                r_sq      <= '0;
            end
            OP_RECT_SETUP: begin
                r_bot   <= rect_bot;
                r_rgt   <= rect_rgt;
                r_r1    <= (rect_bot > FS_LAST) ? FS_LAST : rect_bot;
                r_c1    <= (rect_rgt > FS_LAST) ? FS_LAST : rect_rgt;
                r_c0    <= col_x[PW-1] ? '0 : col_x;
                r_cur_r <= row_x[PW-1] ? '0 : row_x;
                r_cur_c <= col_x[PW-1] ? '0 : col_x;
            end
            OP_RECT_STEP: begin
                if (r_cur_c == r_c1) begin
                    r_cur_c <= r_c0;
                    r_cur_r <= r_cur_r + 1'b1;
                end else begin
                    r_cur_c <= r_cur_c + 1'b1;
                end
            end
            OP_OVAL: begin
                case (i_cmd.step)
                    OV_Q15: begin
                        r_s15 <= q30_to_q15(r_sq);
                        r_c15 <= q30_to_q15(r_cq);
                    end
                    OV_SCALE: begin
                        r_dr <= DR_W'(r_h) * DR_W'(r_s15);
                        r_dc <= DR_W'(r_w) * DR_W'(r_c15);
                    end
                    OV_OFFSET: begin
                        r_pr <= row_x - trunc_q16(r_dr);
                        r_pc <= col_x + trunc_q16(r_dc);
                    end
                    OV_COMMIT: begin
                        r_cq <= r_acc_c;
                        r_sq <= r_acc_s;
                    end
                    default: ;
                endcase
            end
            OP_PUSH: begin
                r_res_pixel <= r_is_read ? i_ram_rdata : PIX_BLACK;
                r_res_read  <= r_is_read;
            end
            default: ;
        endcase
    end

    // frame store port selection
    always_comb begin
        o_ram_we    = 1'b0;
        o_ram_waddr = r_clr_addr;
        o_ram_wdata = PIX_WHITE;
        o_ram_re    = 1'b0;
        o_ram_raddr = pix_addr(row_x, col_x);
        case (i_cmd.op)
            OP_CLEAR: begin
                o_ram_we = 1'b1;
            end
            OP_RECT_STEP: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = pix_addr(r_cur_r, r_cur_c);
                o_ram_wdata = is_border ? PIX_BLACK : PIX_WHITE;
            end
            OP_OVAL: begin
                o_ram_we    = (i_cmd.step == OV_PLOT) && in_frame(r_pr, r_pc);
                o_ram_waddr = pix_addr(r_pr, r_pc);
                o_ram_wdata = PIX_BLACK;
            end
            OP_READ: begin
                o_ram_re = 1'b1;
            end
            default: ;
        endcase
    end

    assign o_status.clear_last    = (r_clr_addr == ADDR_LAST);
    assign o_status.rect_empty    = (r_cur_r > r_r1) || (r_cur_c > r_c1);
    assign o_status.rect_last_col = (r_cur_c == r_c1);
    assign o_status.rect_last_row = (r_cur_r == r_r1);
    assign o_status.out_free      = !r_res_valid || i_res_ready;

    assign o_res_valid = r_res_valid;
    assign o_res_pixel = r_res_pixel;
    assign o_res_read  = r_res_read;

endmodule

FILE: sv/framebuffer_shape_drawer_top.sv
// Channel   Dir  Handshake              Payload
// s_axis    in   tvalid/tready          tdata: row, col, height, width; tuser: mode
// m_axis    out  tvalid/tready          tdata: pixel_value; tuser: is_read
//
// Reset starts a clearing pass, one white pixel per cycle; no request is taken
// until it ends. Requests run one at a time. Rectangle: accept, setup, empty
// check, one write per clipped pixel, post. Read: accept, memory read, post.
// Ellipse: accept; for each of 629 angle points a Q15 conversion, scaling, offset,
// plot, drain and commit, four products per point on one 31x30 multiplier; post.
// A waiting result blocks only the next finished command, not the input.
module framebuffer_shape_drawer_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // [9:0] row, [19:10] col, [29:20] height, [39:30] width
    input  logic [fsd_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    // [1:0] mode
    input  logic [fsd_pkg::MODE_W-1:0]       i_s_axis_tuser,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // [7:0] pixel_value
    output logic [fsd_pkg::PIX_W-1:0]        o_m_axis_tdata,
    // [0] is_read
    output logic                             o_m_axis_tuser
);

    import fsd_pkg::*;

    t_item             item;
    t_cmd              cmd;
    t_status           status;
    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [PIX_W-1:0]  ram_wdata, ram_rdata;

    // unpack the request fields
    assign item.mode   = t_mode'(i_s_axis_tuser);
    assign item.row    = i_s_axis_tdata[FIELD_W-1:0];
    assign item.col    = i_s_axis_tdata[2*FIELD_W-1:FIELD_W];
    assign item.height = i_s_axis_tdata[3*FIELD_W-1:2*FIELD_W];
    assign item.width  = i_s_axis_tdata[4*FIELD_W-1:3*FIELD_W];

    // sequencer: clearing pass, scan order, angle count, result hand-off
    fsd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_mode     (item.mode),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // coordinates, clipping, recurrence pipeline and output register
    fsd_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_item      (item),
        .o_status    (status),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .o_res_valid (o_m_axis_tvalid),
        .i_res_ready (i_m_axis_tready),
        .o_res_pixel (o_m_axis_tdata),
        .o_res_read  (o_m_axis_tuser)
    );

    // frame store, row-major
    fsd_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_frame (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule

FILE: verif/tb_top.sv
module tb_top;
    import fsd_pkg::*;

    // Watchdog: cycles with no request and no result accepted. The slowest
    // single stretch is the clearing pass after reset, or a full-frame
    // rectangle, plus the long receiver hold-off.
    localparam int STALL_LIMIT = 300000;
    localparam int HOLD_CYCLES = 3000;
    localparam int DRAIN_CYCLES = 16;
    localparam int FRAME_LAST = FRAME_SIDE - 1;

    // rotation recurrence for the angle tables, Q30
    localparam longint ROT_ONE_Q30 = 64'd1073741824;
    localparam longint ROT_COS_Q30 = 64'd1073688137;
    localparam longint ROT_SIN_Q30 = 64'd10737239;

    localparam logic [PIX_W-1:0] PIX_INK   = 8'd0;
    localparam logic [PIX_W-1:0] PIX_PAPER = 8'd255;

    // idling per phase of the random part, percent of cycles
    localparam int SRC_IDLE [4]  = '{0, 83, 0, 9};
    localparam int DST_STALL [4] = '{0, 0, 83, 9};

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic             rd;
    } t_pixel_reply;

    typedef struct {
        t_mode m;
        int    r;
        int    c;
        int    h;
        int    w;
        bit    fixed;   // expected reply typed in below, else predicted
        int    pix;
        bit    rd;
    } t_dir_row;

    localparam int DIR_N = 25;

    // Directed requests: reads of the cleared frame and of drawn pixels, reads
    // off the frame, a do-nothing mode, a full-frame rectangle, clipping at both
    // ends, empty rectangles from negative sizes, a one-pixel rectangle, and
    // ellipses, one of them with every field at an end of its range.
    t_dir_row dir_rows [DIR_N] = '{
        '{MODE_READ,    0,    0,    0,    0, 1, 255, 1},
        '{MODE_READ,   -1,    0,    0,    0, 1,   0, 0},
        '{MODE_READ,    0,  256,    0,    0, 1,   0, 0},
        '{MODE_READ, -512,  511,    0,    0, 1,   0, 0},
        '{MODE_NOP,   511, -512,  511, -512, 1,   0, 0},
        '{MODE_RECT,    0,    0,  255,  255, 1,   0, 0},
        '{MODE_READ,    0,    0,    0,    0, 1,   0, 1},
        '{MODE_READ,  128,  128,    0,    0, 1, 255, 1},
        '{MODE_READ,  255,   17,    0,    0, 1,   0, 1},
        '{MODE_RECT,  -10,  -10,   20,   20, 1,   0, 0},
        '{MODE_READ,    0,    0,    0,    0, 1, 255, 1},
        '{MODE_READ,   10,    4,    0,    0, 1,   0, 1},
        '{MODE_RECT,  250,  250,  511,  511, 1,   0, 0},
        '{MODE_READ,  255,  255,    0,    0, 1, 255, 1},
        '{MODE_READ,  250,  253,    0,    0, 1,   0, 1},
        '{MODE_RECT,   20,   20,   -1,    5, 1,   0, 0},
        '{MODE_RECT,   20,   20,    5, -512, 1,   0, 0},
        '{MODE_READ,   20,   20,    0,    0, 1, 255, 1},
        '{MODE_RECT,    5,    5,    0,    0, 1,   0, 0},
        '{MODE_READ,    5,    5,    0,    0, 1,   0, 1},
        '{MODE_OVAL,  128,  128,  100,  100, 1,   0, 0},
        '{MODE_READ,  128,  178,    0,    0, 1,   0, 1},
        '{MODE_OVAL, -512,  511, -512, -512, 1,   0, 0},
        '{MODE_OVAL,  128,  128,  511,  511, 1,   0, 0},
        '{MODE_READ,   28,  128,    0,    0, 0,   0, 0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    // request side, driven at the falling edge
    logic                      s_valid = 1'b0;
    t_mode                     req_mode = MODE_NOP;
    logic signed [FIELD_W-1:0] req_row = '0;
    logic signed [FIELD_W-1:0] req_col = '0;
    logic signed [FIELD_W-1:0] req_h = '0;
    logic signed [FIELD_W-1:0] req_w = '0;
    bit                        req_fixed = 1'b0;
    logic [PIX_W-1:0]          req_pix = '0;
    logic                      req_rd = 1'b0;
    logic                      m_ready = 1'b0;

    wire                 s_ready;
    wire                 m_valid;
    wire [PIX_W-1:0]     m_pix;
    wire                 m_is_read;

    // predictor state: its own copy of the frame and the angle tables
    logic [PIX_W-1:0] frame_pixels [DEPTH];
    int               sin_q15 [ANGLE_POINTS];
    int               cos_q15 [ANGLE_POINTS];
    t_pixel_reply     expected_replies [$];
    int               mismatch_count = 0;

    // knobs for the request driver and the result receiver
    int src_idle_pct = 0;
    int dst_stall_pct = 0;
    bit hold_arm = 1'b0;
    int hold_left = 0;

    // last shape drawn, so that reads can land on its pixels
    t_mode shape_mode = MODE_NOP;
    int    shape_r = 0;
    int    shape_c = 0;
    int    shape_h = 0;
    int    shape_w = 0;

    always #5 i_clk = ~i_clk;

    framebuffer_shape_drawer_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        // [9:0] row, [19:10] col, [29:20] height, [39:30] width
        .i_s_axis_tdata  ({req_w, req_h, req_col, req_row}),
        // [1:0] mode
        .i_s_axis_tuser  (req_mode),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        // [7:0] pixel_value
        .o_m_axis_tdata  (m_pix),
        // [0] is_read
        .o_m_axis_tuser  (m_is_read)
    );

    // a*b / 2^30, rounded half away from zero
    function automatic longint mul_round_q30(longint a, longint b);
        longint unsigned ma, mb, p;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        p = (ma * mb + (64'd1 << 29)) >> 30;
        return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
    endfunction

    // Q30 to Q15, rounded half away from zero, magnitude clamped to 1.0
    function automatic int to_q15(longint v);
        longint unsigned mag, q;
        mag = (v < 0) ? -v : v;
        q = (mag + 64'd16384) >> 15;
        if (q > 64'd32768) begin
            q = 64'd32768;
        end
        return (v < 0) ? -int'(q) : int'(q);
    endfunction

    function automatic bit on_frame(int r, int c);
        return r >= 0 && r < FRAME_SIDE && c >= 0 && c < FRAME_SIDE;
    endfunction

    // Applies one request to the frame copy and returns the reply it causes.
    function automatic t_pixel_reply run_command(t_mode m, int r, int c, int h, int w);
        t_pixel_reply rep;
        int r_lo, r_hi, c_lo, c_hi, rr, cc, k, pr, pc;
        rep = '0;
        case (m)
            MODE_RECT: begin
                // ends inclusive, clipped to the frame; negative sizes give
                // an empty range
                r_lo = (r < 0) ? 0 : r;
                r_hi = (r + h > FRAME_LAST) ? FRAME_LAST : r + h;
                c_lo = (c < 0) ? 0 : c;
                c_hi = (c + w > FRAME_LAST) ? FRAME_LAST : c + w;
                for (rr = r_lo; rr <= r_hi; rr++) begin
                    for (cc = c_lo; cc <= c_hi; cc++) begin
                        frame_pixels[rr * FRAME_SIDE + cc] =
                            (rr == r || rr == r + h || cc == c || cc == c + w) ?
                            PIX_INK : PIX_PAPER;
                    end
                end
            end
            MODE_OVAL: begin
                // int division truncates toward zero
                for (k = 0; k < ANGLE_POINTS; k++) begin
                    pr = r - (h * sin_q15[k]) / 65536;
                    pc = c + (w * cos_q15[k]) / 65536;
                    if (on_frame(pr, pc)) begin
                        frame_pixels[pr * FRAME_SIDE + pc] = PIX_INK;
                    end
                end
            end
            MODE_READ: begin
                if (on_frame(r, c)) begin
                    rep.pix = frame_pixels[r * FRAME_SIDE + c];
                    rep.rd = 1'b1;
                end
            end
            default: ;
        endcase
        return rep;
    endfunction

    task automatic flag_mismatch(string what, int got, int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // cleared frame and angle tables, as after reset
    initial begin
        longint cq, sq, nc, ns;
        int i, k;
        for (i = 0; i < DEPTH; i++) begin
            frame_pixels[i] = PIX_PAPER;
        end
        cq = ROT_ONE_Q30;
        sq = 0;
        for (k = 0; k < ANGLE_POINTS; k++) begin
            cos_q15[k] = to_q15(cq);
            sin_q15[k] = to_q15(sq);
            nc = mul_round_q30(cq, ROT_COS_Q30) - mul_round_q30(sq, ROT_SIN_Q30);
            ns = mul_round_q30(sq, ROT_COS_Q30) + mul_round_q30(cq, ROT_SIN_Q30);
            cq = nc;
            sq = ns;
        end
    end

    // Monitor at the rising edge: results are checked before the request of
    // the same edge is predicted, since a result always belongs to an earlier
    // request. Also runs the no-progress watchdog.
    always @(posedge i_clk) begin
        t_pixel_reply want;
        bit           moved;
        int           quiet;
        moved = 1'b0;
        if (i_rst_n) begin
            if (m_valid && m_ready) begin
                moved = 1'b1;
                if (expected_replies.size() == 0) begin
                    flag_mismatch("result with no request pending, pixel", m_pix, -1);
                end else begin
                    want = expected_replies.pop_front();
                    if (m_pix !== want.pix) begin
                        flag_mismatch("pixel_value", m_pix, want.pix);
                    end
                    if (m_is_read !== want.rd) begin
                        flag_mismatch("is_read", m_is_read, want.rd);
                    end
                end
            end
            if (s_valid && s_ready) begin
                moved = 1'b1;
                want = run_command(req_mode, req_row, req_col, req_h, req_w);
                if (req_fixed) begin
                    want.pix = req_pix;
                    want.rd = req_rd;
                end
                expected_replies.push_back(want);
            end
        end
        quiet = moved ? 0 : quiet + 1;
        if (quiet >= STALL_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // Result receiver: random stalls per phase, or a long hold-off counted
    // here once the request driver arms it.
    always @(negedge i_clk) begin
        if (hold_arm) begin
            hold_left = HOLD_CYCLES;
            hold_arm = 1'b0;
        end
        if (hold_left > 0) begin
            m_ready = 1'b0;
            hold_left--;
        end else begin
            m_ready = ($urandom_range(99) >= dst_stall_pct);
        end
    end

    // Offers one request, starting just after a falling edge, and returns
    // at the falling edge after it was taken. valid stays high between
    // back-to-back requests and drops only in a gap.
    task automatic send_request(t_mode m, int r, int c, int h, int w,
                                bit fixed = 1'b0, int pix = 0, bit rd = 1'b0);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid = 1'b0;
            @(negedge i_clk);
        end
        req_mode = m;
        req_row = r[FIELD_W-1:0];
        req_col = c[FIELD_W-1:0];
        req_h = h[FIELD_W-1:0];
        req_w = w[FIELD_W-1:0];
        req_fixed = fixed;
        req_pix = pix[PIX_W-1:0];
        req_rd = rd;
        s_valid = 1'b1;
        if (m == MODE_RECT || m == MODE_OVAL) begin
            shape_mode = m;
            shape_r = req_row;
            shape_c = req_col;
            shape_h = req_h;
            shape_w = req_w;
        end
        do @(posedge i_clk); while (!s_ready);
        @(negedge i_clk);
    endtask

    // Read aimed at the last shape: a point of the ellipse, or an edge or
    // the inside of the rectangle, with a pixel of jitter now and then.
    task automatic send_probe_read();
        int k, pr, pc;
        if (shape_mode == MODE_OVAL && $urandom_range(3) != 0) begin
            k = $urandom_range(ANGLE_POINTS - 1);
            pr = shape_r - (shape_h * sin_q15[k]) / 65536;
            pc = shape_c + (shape_w * cos_q15[k]) / 65536;
        end else begin
            case ($urandom_range(2))
                0: pr = shape_r;
                1: pr = shape_r + shape_h;
                default: pr = shape_r + ((shape_h > 0) ? int'($urandom_range(shape_h)) : 0);
            endcase
            case ($urandom_range(2))
                0: pc = shape_c;
                1: pc = shape_c + shape_w;
                default: pc = shape_c + ((shape_w > 0) ? int'($urandom_range(shape_w)) : 0);
            endcase
        end
        if ($urandom_range(3) == 0) begin
            pr += int'($urandom_range(2)) - 1;
            pc += int'($urandom_range(2)) - 1;
        end
        send_request(MODE_READ, pr, pc, $urandom, $urandom);
    endtask

    task automatic send_random_request();
        int pick;
        pick = $urandom_range(99);
        if (pick < 35) begin
            send_probe_read();
        end else if (pick < 60) begin
            // small rectangles, some over the frame edges
            send_request(MODE_RECT, int'($urandom_range(290)) - 20,
                         int'($urandom_range(290)) - 20,
                         $urandom_range(24), $urandom_range(24));
        end else if (pick < 70) begin
            send_request(MODE_OVAL, $urandom_range(FRAME_LAST), $urandom_range(FRAME_LAST),
                         $urandom_range(300), $urandom_range(300));
        end else if (pick < 80) begin
            // every field over its whole range
            send_request(MODE_OVAL, $urandom, $urandom, $urandom, $urandom);
        end else if (pick < 87) begin
            send_request(MODE_RECT, $urandom, $urandom, $urandom, $urandom);
        end else if (pick < 95) begin
            send_request(MODE_READ, $urandom, $urandom, $urandom, $urandom);
        end else begin
            send_request(MODE_NOP, $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    initial begin
        int i, ph;
        // reset held, then released; the block then clears the frame on its own
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (i = 0; i < DIR_N; i++) begin
            send_request(dir_rows[i].m, dir_rows[i].r, dir_rows[i].c, dir_rows[i].h,
                         dir_rows[i].w, dir_rows[i].fixed, dir_rows[i].pix, dir_rows[i].rd);
        end

        for (ph = 0; ph < 4; ph++) begin
            src_idle_pct = SRC_IDLE[ph];
            dst_stall_pct = DST_STALL[ph];
            if (ph == 3) begin
                // receiver holds off while reads keep coming: the output
                // register fills, then a finished read stalls the input
                @(posedge i_clk);
                hold_arm = 1'b1;
                @(negedge i_clk);
                repeat (6) send_probe_read();
            end
            repeat (17) send_random_request();
        end

        s_valid = 1'b0;
        src_idle_pct = 0;
        dst_stall_pct = 0;
        while (expected_replies.size() != 0) @(posedge i_clk);
        // then wait out the drain window to catch a stray result
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
